// ===== rtl/core/pisq_pkg.sv =====
// ----------------------------------------------------------------------------
// pisq_pkg
// Shared types and constants for the pending identifier set queue.
// ----------------------------------------------------------------------------
package pisq_pkg;

  localparam int ID_COUNT = 256;
  localparam int ID_W     = 8;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_IGNORED = 1'b1;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [ID_W-1:0] item_id;
  } item_t;

  typedef struct packed {
    logic            head_valid;
    logic [ID_W-1:0] head_id;
    logic            status;
  } result_t;

  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
  } link_t;

  // controller -> successor store
  typedef struct packed {
    logic            wr_en;
    logic [ID_W-1:0] wr_addr;
    logic            wr_valid;
    logic [ID_W-1:0] wr_nxt;
    logic            clr_en;
    logic [ID_W-1:0] clr_addr;
    logic            clr_all;
    logic            rd_en;
    logic [ID_W-1:0] rd_addr;
    logic [ID_W-1:0] va_addr;
    logic [ID_W-1:0] vb_addr;
  } succ_ctl_t;

endpackage

// ===== rtl/core/pisq_succ_store.sv =====
// ----------------------------------------------------------------------------
// pisq_succ_store
// Successor table: identifier RAM with registered read, plus one
// valid flop per entry so reset and clear empty the table at once.
// ----------------------------------------------------------------------------
module pisq_succ_store (
  input  logic                      clk,
  input  logic                      rst,
  input  pisq_pkg::succ_ctl_t       ctl,
  output logic [pisq_pkg::ID_W-1:0] rd_data,
  output logic                      va,
  output logic                      vb
);

  logic [pisq_pkg::ID_W-1:0]     mem [pisq_pkg::ID_COUNT];
  logic [pisq_pkg::ID_COUNT-1:0] vbits;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_nxt;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[ctl.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clr_all) begin
      vbits <= '0;
    end else begin
      if (ctl.wr_en) begin
        vbits[ctl.wr_addr] <= ctl.wr_valid;
      end
      if (ctl.clr_en) begin
        vbits[ctl.clr_addr] <= 1'b0;
      end
    end
  end

  assign va = vbits[ctl.va_addr];
  assign vb = vbits[ctl.vb_addr];

endmodule

// ===== rtl/core/pisq_ctrl.sv =====
// ----------------------------------------------------------------------------
// pisq_ctrl
// Command sequencer: holds head and tail pointers, runs insert, remove
// (head pop or list walk) and clear against the successor store.
// ----------------------------------------------------------------------------
module pisq_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  pisq_pkg::item_t           item,
  output logic                      busy,
  output logic                      done,
  output pisq_pkg::result_t         result,
  output pisq_pkg::succ_ctl_t       ctl,
  input  logic [pisq_pkg::ID_W-1:0] rd_data,
  input  logic                      va,
  input  logic                      vb
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_HEAD = 3'd2;
  localparam logic [2:0] ST_WALK = 3'd3;
  localparam logic [2:0] ST_LINK = 3'd4;

  logic [2:0]                state, state_next;
  logic [1:0]                cmd_q;
  logic [pisq_pkg::ID_W-1:0] id_q;
  logic [pisq_pkg::ID_W-1:0] prev, prev_next;
  pisq_pkg::link_t           head, head_next;
  pisq_pkg::link_t           tail, tail_next;
  logic                      fin;
  logic                      fin_status;

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next  = state;
    prev_next   = prev;
    head_next   = head;
    tail_next   = tail;
    fin         = 1'b0;
    fin_status  = pisq_pkg::STATUS_DONE;
    ctl         = '0;
    ctl.va_addr = head.id;
    ctl.vb_addr = id_q;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (cmd_q)
          pisq_pkg::CMD_INSERT: begin
            fin = 1'b1;
            if ((tail.valid && tail.id == id_q) || vb) begin
              fin_status = pisq_pkg::STATUS_IGNORED;
            end else begin
              if (!head.valid) begin
                head_next = '{valid: 1'b1, id: id_q};
              end else if (tail.valid) begin
                ctl.wr_en    = 1'b1;
                ctl.wr_addr  = tail.id;
                ctl.wr_valid = 1'b1;
                ctl.wr_nxt   = id_q;
              end
              tail_next = '{valid: 1'b1, id: id_q};
            end
          end
          pisq_pkg::CMD_REMOVE: begin
            if (!head.valid) begin
              fin        = 1'b1;
              fin_status = pisq_pkg::STATUS_IGNORED;
            end else if (head.id == id_q) begin
              ctl.rd_en   = 1'b1;
              ctl.rd_addr = id_q;
              state_next  = ST_HEAD;
            end else if (!va) begin
              // head has no successor, so the id is not queued
              fin        = 1'b1;
              fin_status = pisq_pkg::STATUS_IGNORED;
            end else begin
              prev_next   = head.id;
              ctl.rd_en   = 1'b1;
              ctl.rd_addr = head.id;
              state_next  = ST_WALK;
            end
          end
          pisq_pkg::CMD_CLEAR: begin
            fin         = 1'b1;
            head_next   = '0;
            tail_next   = '0;
            ctl.clr_all = 1'b1;
          end
          default: begin
            fin        = 1'b1;
            fin_status = pisq_pkg::STATUS_IGNORED;
          end
        endcase
      end
      ST_HEAD: begin
        fin          = 1'b1;
        ctl.clr_en   = 1'b1;
        ctl.clr_addr = id_q;
        if (vb) begin
          head_next = '{valid: 1'b1, id: rd_data};
        end else begin
          head_next = '0;
          tail_next = '0;
        end
      end
      ST_WALK: begin
        // rd_data is the successor of prev
        ctl.va_addr = rd_data;
        if (rd_data == id_q) begin
          ctl.rd_en   = 1'b1;
          ctl.rd_addr = id_q;
          state_next  = ST_LINK;
        end else begin
          prev_next = rd_data;
          if (!va) begin
            fin        = 1'b1;
            fin_status = pisq_pkg::STATUS_IGNORED;
          end else begin
            ctl.rd_en   = 1'b1;
            ctl.rd_addr = rd_data;
          end
        end
      end
      ST_LINK: begin
        // unlink: prev takes over the successor of the removed id
        fin          = 1'b1;
        ctl.wr_en    = 1'b1;
        ctl.wr_addr  = prev;
        ctl.wr_valid = vb;
        ctl.wr_nxt   = rd_data;
        ctl.clr_en   = 1'b1;
        ctl.clr_addr = id_q;
        if (tail.valid && tail.id == id_q) begin
          tail_next.id = prev;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (fin) begin
      state_next = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      tail  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      done  <= fin;
    end
  end

  always_ff @(posedge clk) begin
    prev <= prev_next;
    if (start && !busy) begin
      cmd_q <= item.cmd;
      id_q  <= item.item_id;
    end
    if (fin) begin
      result.head_valid <= head_next.valid;
      result.head_id    <= head_next.valid ? head_next.id : '0;
      result.status     <= fin_status;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe on back-to-back cycles");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");
  a_ptr_agree: assert property (@(posedge clk) disable iff (rst)
    head.valid == tail.valid)
    else $error("head and tail valid disagree");

endmodule

// ===== rtl/core/pending_id_set_queue_top.sv =====
// ----------------------------------------------------------------------------
// pending_id_set_queue_top
// Ordered queue of unique pending identifiers kept as a linked list.
// ----------------------------------------------------------------------------
// Command channel: drive item (cmd, item_id) with start; the transfer happens
// on the rising edge where start is high and busy is low. busy stays high
// while the command runs.
// Result channel: done pulses for one cycle with result (head_valid,
// head_id, status); the receiver must take it in that cycle.
// Command flow is set by successor RAM reads:
//   insert, clear, unused code, remove from empty queue: execute state only
//   remove of the head: execute, then the head state after the RAM read
//   remove further down: execute, walk states that read one successor per
//   link up to the match (one RAM read per link), then the link state; a miss ends at the tail.
// A new command is taken in the cycle done is high.
// Reset (rst, synchronous) empties the queue at once: head, tail and every
// successor valid flop clear together, no sweep.
// ----------------------------------------------------------------------------
module pending_id_set_queue_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  pisq_pkg::item_t     item,
  output logic                busy,
  output logic                done,
  output pisq_pkg::result_t   result
);

  pisq_pkg::succ_ctl_t       ctl;
  logic [pisq_pkg::ID_W-1:0] rd_data;
  logic                      va;
  logic                      vb;

  pisq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .item    (item),
    .busy    (busy),
    .done    (done),
    .result  (result),
    .ctl     (ctl),
    .rd_data (rd_data),
    .va      (va),
    .vb      (vb)
  );

  pisq_succ_store u_store (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .rd_data (rd_data),
    .va      (va),
    .vb      (vb)
  );

endmodule

// ===== tb/sv/pisq_checker.sv =====
// ----------------------------------------------------------------------------
// pisq_checker
// Watches the command and result channels of the pending identifier set
// queue. It predicts each result from a linked-list model of its own and
// compares it, field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module pisq_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  pisq_pkg::item_t   item,
  input  logic              done,
  input  pisq_pkg::result_t result,
  output int                fail_count,
  output int                pending
);

  pisq_pkg::link_t   head_link;
  pisq_pkg::link_t   tail_link;
  pisq_pkg::link_t   next_link [pisq_pkg::ID_COUNT];
  pisq_pkg::result_t expected_heads [$];
  pisq_pkg::result_t want;
  int                result_index;

  function automatic void empty_queue_model();
    head_link = '0;
    tail_link = '0;
    for (int k = 0; k < pisq_pkg::ID_COUNT; k++) next_link[k] = '0;
  endfunction

  // Applies one command to the model and returns the head it leaves behind.
  function automatic pisq_pkg::result_t apply_command(pisq_pkg::item_t it);
    pisq_pkg::result_t         r;
    logic                      ignored;
    logic [pisq_pkg::ID_W-1:0] id;
    logic [pisq_pkg::ID_W-1:0] prev;
    logic                      found;
    logic                      walking;
    int                        steps;
    id      = it.item_id;
    ignored = pisq_pkg::STATUS_DONE;
    found   = 1'b0;
    walking = 1'b1;
    steps   = 0;
    case (it.cmd)
      pisq_pkg::CMD_INSERT: begin
        if ((tail_link.valid && tail_link.id == id) || next_link[id].valid) begin
          ignored = pisq_pkg::STATUS_IGNORED;
        end else begin
          if (!head_link.valid) begin
            head_link = '{valid: 1'b1, id: id};
          end else if (tail_link.valid) begin
            next_link[tail_link.id] = '{valid: 1'b1, id: id};
          end
          tail_link = '{valid: 1'b1, id: id};
        end
      end
      pisq_pkg::CMD_REMOVE: begin
        if (!head_link.valid) begin
          ignored = pisq_pkg::STATUS_IGNORED;
        end else if (head_link.id == id) begin
          head_link = next_link[id];
          if (!head_link.valid) begin
            head_link = '0;
            tail_link = '0;
          end
          next_link[id] = '0;
        end else begin
          // find the predecessor by walking from the head
          prev = head_link.id;
          while (walking && steps < pisq_pkg::ID_COUNT) begin
            if (!next_link[prev].valid) begin
              walking = 1'b0;
            end else if (next_link[prev].id == id) begin
              found   = 1'b1;
              walking = 1'b0;
            end else begin
              prev = next_link[prev].id;
            end
            steps++;
          end
          if (!found) begin
            ignored = pisq_pkg::STATUS_IGNORED;
          end else begin
            next_link[prev] = next_link[id];
            if (tail_link.valid && tail_link.id == id) tail_link.id = prev;
            next_link[id] = '0;
          end
        end
      end
      pisq_pkg::CMD_CLEAR: empty_queue_model();
      default: ignored = pisq_pkg::STATUS_IGNORED;
    endcase
    r.head_valid = head_link.valid;
    r.head_id    = head_link.valid ? head_link.id : '0;
    r.status     = ignored;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      empty_queue_model();
      expected_heads.delete();
      result_index = 0;
    end else begin
      // compare first: a result and the next command can share one edge
      if (done) begin
        if (expected_heads.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result %0d: unexpected transfer valid=%0b id=%0d status=%0b",
                     result_index, result.head_valid, result.head_id, result.status);
        end else begin
          want = expected_heads.pop_front();
          if (result.head_valid !== want.head_valid || result.head_id !== want.head_id ||
              result.status !== want.status) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"result %0d: expected valid=%0b id=%0d status=%0b,",
                        " got valid=%0b id=%0d status=%0b"},
                       result_index, want.head_valid, want.head_id, want.status,
                       result.head_valid, result.head_id, result.status);
          end
        end
        result_index++;
      end
      if (start && !busy) expected_heads.push_back(apply_command(item));
    end
    pending = expected_heads.size();
  end

endmodule

// ===== tb/sv/tb_pending_id_set_queue_top.sv =====
// ----------------------------------------------------------------------------
// tb_pending_id_set_queue_top
// Drives directed and random insert, remove, clear and unused-code commands into the
// pending identifier set queue in bursts with random gaps; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_pending_id_set_queue_top;

  localparam int         RANDOM_ITEMS = 1350;
  localparam int         CYCLE_LIMIT  = 4000000;
  localparam int         DRAIN_CYCLES = 300;
  localparam logic [1:0] CMD_UNUSED   = 2'd3;

  logic              clk   = 1'b0;
  logic              rst   = 1'b1;
  logic              start = 1'b0;
  pisq_pkg::item_t   item  = '0;
  logic              busy;
  logic              done;
  pisq_pkg::result_t result;
  int                fail_count;
  int                pending_count;
  int                cycle_count = 0;
  int                sent_count  = 0;
  int                burst_left  = 0;
  logic              start_level = 1'b0;

  always #4 clk = ~clk;

  pending_id_set_queue_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  pisq_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .item       (item),
    .done       (done),
    .result     (result),
    .fail_count (fail_count),
    .pending    (pending_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_pending_id_set_queue_top NOT OK");
      $finish;
    end
  end

  // One command transfer; start stays high across a burst.
  task automatic send_command(input logic [1:0] c,
                              input logic [pisq_pkg::ID_W-1:0] id);
    int gap;
    item        <= '{cmd: c, item_id: id};
    start       <= 1'b1;
    start_level = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    sent_count++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start       <= 1'b0;
      start_level = 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                              : $urandom_range(0, 8);
    end
  endtask

  task automatic churn();
    int                        r;
    logic [pisq_pkg::ID_W-1:0] base;
    base = pisq_pkg::ID_W'($urandom);
    for (int k = 0; k < 30; k++) begin
      r = $urandom_range(0, 99);
      if (r < 48)
        send_command(pisq_pkg::CMD_INSERT, base + pisq_pkg::ID_W'($urandom_range(0, 7)));
      else if (r < 94)
        send_command(pisq_pkg::CMD_REMOVE, base + pisq_pkg::ID_W'($urandom_range(0, 7)));
      else if (r < 97)
        send_command(pisq_pkg::CMD_CLEAR, pisq_pkg::ID_W'($urandom));
      else
        send_command(CMD_UNUSED, pisq_pkg::ID_W'($urandom));
    end
  endtask

  task automatic noise();
    for (int k = 0; k < 20; k++)
      send_command(2'($urandom_range(0, 3)), pisq_pkg::ID_W'($urandom));
  endtask

  // Fill with distinct ids, then remove all or half in order, reverse order or shuffled.
  task automatic fill_and_drain();
    logic [pisq_pkg::ID_W-1:0] ids [pisq_pkg::ID_COUNT];
    logic [pisq_pkg::ID_W-1:0] tmp;
    int                        n, m, base, stride, order, j;
    n      = ($urandom_range(0, 5) == 0) ? pisq_pkg::ID_COUNT : $urandom_range(2, 40);
    m      = ($urandom_range(0, 3) == 0) ? n / 2 : n;
    base   = $urandom_range(0, pisq_pkg::ID_COUNT - 1);
    stride = 2 * $urandom_range(0, 127) + 1;
    for (int k = 0; k < n; k++) begin
      ids[k] = pisq_pkg::ID_W'(base + k * stride);
      send_command(pisq_pkg::CMD_INSERT, ids[k]);
      if ($urandom_range(0, 9) == 0)
        send_command(pisq_pkg::CMD_INSERT, ids[$urandom_range(0, k)]);
    end
    order = $urandom_range(0, 2);
    if (order == 2) begin
      for (int k = n - 1; k > 0; k--) begin
        j      = $urandom_range(0, k);
        tmp    = ids[k];
        ids[k] = ids[j];
        ids[j] = tmp;
      end
    end
    for (int k = 0; k < m; k++) begin
      if ($urandom_range(0, 9) == 0)
        send_command(pisq_pkg::CMD_REMOVE, pisq_pkg::ID_W'($urandom));
      send_command(pisq_pkg::CMD_REMOVE, (order == 1) ? ids[n - 1 - k] : ids[k]);
    end
    if ($urandom_range(0, 2) == 0)
      send_command(pisq_pkg::CMD_CLEAR, pisq_pkg::ID_W'($urandom));
  endtask

  initial begin
    int target;
    int seg;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    burst_left = $urandom_range(0, 8);

    send_command(pisq_pkg::CMD_REMOVE, 8'd5);    // remove from empty queue
    send_command(pisq_pkg::CMD_CLEAR, 8'd0);     // clear while empty
    send_command(pisq_pkg::CMD_INSERT, 8'd0);
    send_command(pisq_pkg::CMD_INSERT, 8'd255);
    send_command(pisq_pkg::CMD_INSERT, 8'd0);    // duplicate
    send_command(pisq_pkg::CMD_INSERT, 8'd128);
    send_command(pisq_pkg::CMD_REMOVE, 8'd128);  // tail removal moves tail back
    send_command(pisq_pkg::CMD_INSERT, 8'd7);    // must link after the new tail
    send_command(pisq_pkg::CMD_REMOVE, 8'd255);  // middle
    send_command(pisq_pkg::CMD_REMOVE, 8'd99);   // not queued
    send_command(pisq_pkg::CMD_REMOVE, 8'd255);  // already gone
    send_command(CMD_UNUSED, 8'd170);
    send_command(pisq_pkg::CMD_REMOVE, 8'd0);    // head
    send_command(pisq_pkg::CMD_REMOVE, 8'd7);    // last entry
    send_command(pisq_pkg::CMD_INSERT, 8'd85);
    send_command(pisq_pkg::CMD_INSERT, 8'd170);
    send_command(pisq_pkg::CMD_CLEAR, 8'd255);
    send_command(pisq_pkg::CMD_INSERT, 8'd170);
    send_command(pisq_pkg::CMD_REMOVE, 8'd170);
    send_command(pisq_pkg::CMD_INSERT, 8'd1);
    send_command(pisq_pkg::CMD_INSERT, 8'd2);
    send_command(pisq_pkg::CMD_INSERT, 8'd3);
    send_command(pisq_pkg::CMD_REMOVE, 8'd3);
    send_command(pisq_pkg::CMD_INSERT, 8'd3);
    send_command(pisq_pkg::CMD_REMOVE, 8'd2);

    target = sent_count + RANDOM_ITEMS;
    while (sent_count < target) begin
      seg = $urandom_range(0, 9);
      if (seg < 4)      churn();
      else if (seg < 8) fill_and_drain();
      else              noise();
    end
    if (start_level) start <= 1'b0;

    do @(negedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb_pending_id_set_queue_top OK");
    end else begin
      $display("tb_pending_id_set_queue_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/pisq_pkg.sv
rtl/core/pisq_succ_store.sv
rtl/core/pisq_ctrl.sv
rtl/core/pending_id_set_queue_top.sv
tb/sv/pisq_checker.sv
tb/sv/tb_pending_id_set_queue_top.sv
